/* sv/bsbb_pkg.sv */
// shared types and constants for the byte stream bus bridge
`timescale 1ns / 1ps
`default_nettype none

package bsbb_pkg;

  // command codes, low nibble of the first header byte
  localparam logic [3:0] CMD_NOP   = 4'h0;
  localparam logic [3:0] CMD_WRITE = 4'h1;
  localparam logic [3:0] CMD_READ  = 4'h2;
  localparam logic [3:0] CMD_GPWR  = 4'h3;
  localparam logic [3:0] CMD_GPRD  = 4'h4;

  // result kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_RREQ  = 2'd1;
  localparam logic [1:0] KIND_REPLY = 2'd2;
  localparam logic [1:0] KIND_GPIO  = 2'd3;

  // most results one request can cause
  localparam int unsigned MAX_RESULTS = 5;

  // shape of the group of results one request causes
  typedef enum logic [2:0] {
    MODE_WRITE,   // one bus write
    MODE_RREQ,    // one bus read request
    MODE_RRESP,   // four reply bytes, maybe a further read request
    MODE_GPRD,    // one reply byte with the pin levels
    MODE_GPWR     // one gpio latch update
  } mode_t;

  typedef struct packed {
    logic [2:0]  count;  // number of results, zero when none
    mode_t       mode;
    logic [31:0] word;   // write word or read response word
    logic [31:0] addr;   // word-aligned bus address
    logic [7:0]  data;   // pin levels or gpio value
  } bundle_t;

endpackage

`default_nettype wire

/* sv/bsbb_parser.sv */
// header parser, write packer and read tracker: one request per cycle while take is high
`timescale 1ns / 1ps
`default_nettype none

module bsbb_parser import bsbb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic        func,
  input  wire logic [7:0]  host_byte,
  input  wire logic [31:0] read_word,
  input  wire logic [7:0]  gpio_pins,
  output bundle_t          bundle
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LENLO,
    PH_ADDR,
    PH_WDATA,
    PH_RWAIT,
    PH_GPVAL
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  command, command_next;
  logic [11:0] length_bytes, length_bytes_next;
  logic [31:0] address, address_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [23:0] word_buffer, word_buffer_next;
  logic [9:0]  words_left, words_left_next;
  logic        read_pending, read_pending_next;

  logic [31:0] addr_inc;
  logic [31:0] addr_shift;
  logic [12:0] len_round;
  logic [10:0] words;

  assign addr_inc   = address + 32'd4;
  assign addr_shift = {address[23:0], host_byte};
  assign len_round  = {1'b0, length_bytes} + 13'd3;
  assign words      = len_round[12:2];

  // next state and results for the request at the input
  always_comb begin
    phase_next        = phase;
    command_next      = command;
    length_bytes_next = length_bytes;
    address_next      = address;
    byte_index_next   = byte_index;
    word_buffer_next  = word_buffer;
    words_left_next   = words_left;
    read_pending_next = read_pending;
    bundle            = '0;
    bundle.mode       = MODE_WRITE;

    if (func) begin
      // bus response word, only while a read is outstanding
      if (phase == PH_RWAIT && read_pending) begin
        bundle.mode = MODE_RRESP;
        bundle.word = read_word;
        if (words_left == 10'd0) begin
          bundle.count      = 3'd4;
          read_pending_next = 1'b0;
          phase_next        = PH_IDLE;
        end else begin
          bundle.count    = 3'd5;
          bundle.addr     = {addr_inc[31:2], 2'b00};
          words_left_next = words_left - 10'd1;
          address_next    = addr_inc;
        end
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (host_byte[3:0] == CMD_WRITE || host_byte[3:0] == CMD_READ) begin
            command_next      = host_byte[2:0];
            length_bytes_next = {host_byte[7:4], 8'h00};
            phase_next        = PH_LENLO;
          end else if (host_byte[3:0] == CMD_GPWR) begin
            command_next = host_byte[2:0];
            phase_next   = PH_GPVAL;
          end else if (host_byte[3:0] == CMD_GPRD) begin
            command_next = host_byte[2:0];
            bundle.count = 3'd1;
            bundle.mode  = MODE_GPRD;
            bundle.data  = gpio_pins;
          end
        end
        PH_LENLO: begin
          length_bytes_next = {length_bytes[11:8], host_byte};
          address_next      = '0;
          byte_index_next   = 2'd0;
          phase_next        = PH_ADDR;
        end
        PH_ADDR: begin
          address_next    = addr_shift;
          byte_index_next = byte_index + 2'd1;
          // last address byte: start the transfer
          if (byte_index == 2'd3) begin
            if (words == 11'd0) begin
              phase_next = PH_IDLE;
            end else begin
              words_left_next  = words[9:0] - 10'd1;
              word_buffer_next = '0;
              if (command == CMD_READ[2:0]) begin
                read_pending_next = 1'b1;
                phase_next        = PH_RWAIT;
                bundle.count      = 3'd1;
                bundle.mode       = MODE_RREQ;
                bundle.addr       = {addr_shift[31:2], 2'b00};
              end else begin
                phase_next = PH_WDATA;
              end
            end
          end
        end
        PH_WDATA: begin
          if (byte_index != 2'd3) begin
            word_buffer_next = word_buffer | (24'(host_byte) << {byte_index, 3'b000});
            byte_index_next  = byte_index + 2'd1;
          end else begin
            // fourth byte completes the word
            bundle.count     = 3'd1;
            bundle.mode      = MODE_WRITE;
            bundle.word      = {host_byte, word_buffer};
            bundle.addr      = {address[31:2], 2'b00};
            word_buffer_next = '0;
            byte_index_next  = 2'd0;
            address_next     = addr_inc;
            if (words_left == 10'd0) begin
              phase_next = PH_IDLE;
            end else begin
              words_left_next = words_left - 10'd1;
            end
          end
        end
        PH_GPVAL: begin
          bundle.count = 3'd1;
          bundle.mode  = MODE_GPWR;
          bundle.data  = host_byte;
          phase_next   = PH_IDLE;
        end
        PH_RWAIT: begin
          // host bytes are dropped while a read is outstanding
        end
        default: begin
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      command      <= '0;
      length_bytes <= '0;
      address      <= '0;
      byte_index   <= '0;
      word_buffer  <= '0;
      words_left   <= '0;
      read_pending <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      command      <= command_next;
      length_bytes <= length_bytes_next;
      address      <= address_next;
      byte_index   <= byte_index_next;
      word_buffer  <= word_buffer_next;
      words_left   <= words_left_next;
      read_pending <= read_pending_next;
    end
  end

endmodule

`default_nettype wire

/* sv/bsbb_emitter.sv */
// result register: holds one group of results and hands them out one a cycle while out_ready is high
`timescale 1ns / 1ps
`default_nettype none

module bsbb_emitter import bsbb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire bundle_t     bundle,
  output logic             can_take,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [31:0]      bus_address,
  output logic [31:0]      bus_wdata,
  output logic [7:0]       reply_byte,
  output logic [7:0]       gpio_value,
  output logic             last
);

  bundle_t    held;
  logic       held_valid;
  logic [2:0] idx;
  logic       fire;

  assign out_valid = held_valid;
  assign last      = (idx == (held.count - 3'd1));
  assign fire      = held_valid && out_ready;
  // free now, or the final result leaves in this cycle
  assign can_take  = !held_valid || (out_ready && last);

  // group register and result index
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      idx        <= '0;
    end else if (take && bundle.count != 3'd0) begin
      // a new group replaces the one whose final result leaves now
      held_valid <= 1'b1;
      idx        <= '0;
    end else if (fire) begin
      if (last) begin
        held_valid <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && bundle.count != 3'd0) begin
      held <= bundle;
    end
  end

  // result fields for the current index
  always_comb begin
    kind        = KIND_WRITE;
    bus_address = '0;
    bus_wdata   = '0;
    reply_byte  = '0;
    gpio_value  = '0;
    unique case (held.mode)
      MODE_WRITE: begin
        kind        = KIND_WRITE;
        bus_address = held.addr;
        bus_wdata   = held.word;
      end
      MODE_RREQ: begin
        kind        = KIND_RREQ;
        bus_address = held.addr;
      end
      MODE_RRESP: begin
        if (idx == 3'(MAX_RESULTS - 1)) begin
          kind        = KIND_RREQ;
          bus_address = held.addr;
        end else begin
          kind       = KIND_REPLY;
          reply_byte = held.word[{idx[1:0], 3'b000} +: 8];
        end
      end
      MODE_GPRD: begin
        kind       = KIND_REPLY;
        reply_byte = held.data;
      end
      MODE_GPWR: begin
        kind       = KIND_GPIO;
        gpio_value = held.data;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/byte_stream_bus_bridge.sv */
// top level of the byte stream to memory bus bridge
//
// Input channel (in_valid/in_ready): each request carries func, host_byte,
// read_word and gpio_pins. func 0 is a byte from the host, func 1 a bus
// read response word. Output channel (out_valid/out_ready): each result
// carries kind, bus_address, bus_wdata, reply_byte, gpio_value and last.
// A request is parsed in the cycle it is accepted; its results appear
// from the next cycle, one per cycle while out_ready is high, last
// marking the final one. A request causes zero to five results: one for
// a write word, gpio value, gpio read or last read address byte, four
// reply bytes and possibly the next read request for a read response,
// none for other header bytes. Throughput is one request per cycle while
// out_ready is high and requests cause at most one result each; else one
// request per result, set by the single result register draining one
// result a cycle. in_ready is high while the final result is taken.
// Reset (synchronous, active high) returns the parser to waiting for a
// command byte and empties the result register. When the receiver
// stalls, the result register holds and in_ready falls until it drains.
`timescale 1ns / 1ps
`default_nettype none

module byte_stream_bus_bridge import bsbb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        func,
  input  wire logic [7:0]  host_byte,
  input  wire logic [31:0] read_word,
  input  wire logic [7:0]  gpio_pins,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [31:0]      bus_address,
  output logic [31:0]      bus_wdata,
  output logic [7:0]       reply_byte,
  output logic [7:0]       gpio_value,
  output logic             last
);

  bundle_t bundle;
  logic    take;
  logic    can_take;

  assign in_ready = can_take;
  assign take     = in_valid && can_take;

  // parser and state
  bsbb_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .func      (func),
    .host_byte (host_byte),
    .read_word (read_word),
    .gpio_pins (gpio_pins),
    .bundle    (bundle)
  );

  // result register
  bsbb_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .bundle      (bundle),
    .can_take    (can_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .bus_address (bus_address),
    .bus_wdata   (bus_wdata),
    .reply_byte  (reply_byte),
    .gpio_value  (gpio_value),
    .last        (last)
  );

  // a request enters only as the held group finishes
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && out_valid) |-> (last && out_ready))
    else $error("request accepted while results still held");

  // bus writes and gpio updates come alone
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_WRITE || kind == KIND_GPIO)) |-> last)
    else $error("write or gpio result not marked last");

  // nothing follows the final result without a new request
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last && !(in_valid && in_ready)) |=> !out_valid)
    else $error("result shown after group finished");

endmodule

`default_nettype wire
